// ----- rtl/core/gncr_pkg.sv -----
// Package for the grid neighbor count removal pass.
// Holds the item structs, the window column type, cell codes and register indexes.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gncr_pkg;

   localparam int CODE_W      = 2;
   localparam int COUNT_W     = 24;
   localparam int ROWS_W      = 16;
   localparam int ROW_W       = ROWS_W + 1;
   localparam int THR_W       = 4;
   localparam int LENGTH_W    = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CODE_W-1:0] CODE_EMPTY    = 2'd0;
   localparam logic [CODE_W-1:0] CODE_OCCUPIED = 2'd1;
   localparam logic [CODE_W-1:0] CODE_REMOVED  = 2'd2;
   localparam logic [CODE_W-1:0] CODE_INVALID  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = 24'hFFFFFF;
   localparam logic [ROWS_W-1:0]  ROWS_RESET    = 16'd256;
   localparam logic [THR_W-1:0]   THR_RESET     = 4'd4;

   typedef struct packed {
      logic [CODE_W-1:0] cell_code;
      logic              pad;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  new_cell_code;
      logic [COUNT_W-1:0] removed_total;
      logic               last_cell;
   } rsp_type;

   // One column of the 3x3 window: row above, center row, row below.
   typedef struct packed {
      logic [CODE_W-1:0] top;
      logic [CODE_W-1:0] mid;
      logic [CODE_W-1:0] bot;
   } column_type;

   // Edge masks for one decision.
   typedef struct packed {
      logic no_top;
      logic no_left;
      logic no_right;
   } mask_type;

endpackage

`default_nettype wire

// ----- rtl/core/gncr_column_cell.sv -----
// One cell of the window chain: holds one window column and takes its neighbor's.
// Depends on gncr_pkg for the column type.
`timescale 1ns / 1ps
`default_nettype none

module gncr_column_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                shift_en,
   input  wire gncr_pkg::column_type column_feed,
   output gncr_pkg::column_type      column_out
);

   gncr_pkg::column_type column_ff;
   gncr_pkg::column_type column_in;

   always_comb begin
      column_in = shift_en ? column_feed : column_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '{top: gncr_pkg::CODE_EMPTY, mid: gncr_pkg::CODE_EMPTY,
                        bot: gncr_pkg::CODE_EMPTY};
      end else begin
         column_ff <= column_in;
      end
   end

   assign column_out = column_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gncr_row_store.sv -----
// Line store for the two previous rows, one entry of both rows per column.
// Write-first read with registered data; depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module gncr_row_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read of the address being written returns the new data.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gncr_judge.sv -----
// Neighbor count and removal decision for the center of a 3x3 window.
// Depends on gncr_pkg for cell codes, the column type and the mask type.
`timescale 1ns / 1ps
`default_nettype none

module gncr_judge (
   input  wire gncr_pkg::column_type          left_col,
   input  wire gncr_pkg::column_type          center_col,
   input  wire gncr_pkg::column_type          right_col,
   input  wire gncr_pkg::mask_type            mask,
   input  wire logic [gncr_pkg::THR_W-1:0]    threshold,
   output logic      [gncr_pkg::CODE_W-1:0]   new_code,
   output logic                               remove
);

   function automatic logic [3:0] occ(input logic [gncr_pkg::CODE_W-1:0] v);
      return (v == gncr_pkg::CODE_OCCUPIED) ? 4'd1 : 4'd0;
   endfunction

   logic [3:0] count;

   always_comb begin
      count = 4'd0;
      if (!mask.no_left) begin
         count = count + occ(left_col.mid) + occ(left_col.bot);
         if (!mask.no_top) begin
            count = count + occ(left_col.top);
         end
      end
      count = count + occ(center_col.bot);
      if (!mask.no_top) begin
         count = count + occ(center_col.top);
      end
      if (!mask.no_right) begin
         count = count + occ(right_col.mid) + occ(right_col.bot);
         if (!mask.no_top) begin
            count = count + occ(right_col.top);
         end
      end
   end

   always_comb begin
      remove   = 1'b0;
      new_code = gncr_pkg::CODE_EMPTY;
      case (center_col.mid)
         gncr_pkg::CODE_REMOVED: begin
            new_code = gncr_pkg::CODE_REMOVED;
         end
         gncr_pkg::CODE_OCCUPIED: begin
            remove   = (count < threshold);
            new_code = remove ? gncr_pkg::CODE_REMOVED : gncr_pkg::CODE_OCCUPIED;
         end
         default: begin
            new_code = gncr_pkg::CODE_EMPTY;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/grid_neighbor_count_removal_pass.sv -----
// Top level of the grid neighbor count removal pass (3x3 erosion, one pass).
// Depends on gncr_pkg, gncr_column_cell, gncr_row_store and gncr_judge.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one grid cell per item in raster order and accepts one item
// every clock cycle unless its full output register is held; nothing inside it
// iterates, so the rate is set only by that register, which can hold one
// finished result while the next item is taken. Results lag inputs by one row
// plus one cell, so after the last row the host sends row_length plus one pad
// items to flush the frame; the result that carries last_cell marks the end,
// and position and removal count then start over for the next frame. A pad item
// sent at the start of a frame is swallowed without a result. The window is a
// chain of three column cells that shift left on each item not swallowed, fed
// by a single line store that holds the two previous rows for each column. The
// store needs no clearing pass after reset: reads from rows above the frame and
// from left neighbors outside it are masked to empty. Writing row_length or
// row_count restarts the frame; neighbor_threshold takes effect at once.
// Configuration must be written only while no item is in flight (not enforced).

module grid_neighbor_count_removal_pass #(
   parameter int MAX_ROW_LENGTH = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire gncr_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output gncr_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_write_en,
   input  wire logic [gncr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [gncr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int COL_W     = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W     = $clog2(MAX_ROW_LENGTH + 1);
   localparam int RESET_LEN = (256 > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : 256;
   localparam int ROW_W     = gncr_pkg::ROW_W;
   localparam int ROWS_W    = gncr_pkg::ROWS_W;
   localparam int COUNT_W   = gncr_pkg::COUNT_W;
   localparam int CODE_W    = gncr_pkg::CODE_W;

   // Position, count and configuration registers.
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [COUNT_W-1:0]          count_ff, count_in, count_upd;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [ROWS_W-1:0]           rows_ff, rows_in;
   logic [gncr_pkg::THR_W-1:0]  thr_ff, thr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   gncr_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // Item control.
   logic                        accept;
   logic                        ignore_pad;
   logic                        step;
   logic                        path_end;
   logic                        path_mid;
   logic                        emit;
   logic                        last;
   logic                        row_done;
   logic [CODE_W-1:0]           new_entry;
   logic [ROW_W-1:0]            rows_ext;
   logic [ROW_W-1:0]            rows_p1;
   logic [LEN_W-1:0]            col_ext;
   logic [31:0]                 len_wr;

   gncr_pkg::mask_type          mask;
   gncr_pkg::column_type        right_col;
   gncr_pkg::column_type        win  [3];
   gncr_pkg::column_type        feed [3];
   logic [3:0]                  store_rd;
   logic [3:0]                  store_wr;
   logic [CODE_W-1:0]           judge_code;
   logic                        judge_remove;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign ignore_pad = req_data.pad && (col_ff == '0) && (row_ff == '0);
   assign step       = accept && !ignore_pad;

   assign rows_ext = {1'b0, rows_ff};
   assign rows_p1  = rows_ext + ROW_W'(1);
   assign col_ext  = LEN_W'(col_ff);

   // Pads, rows past the frame and the unused code enter the window as empty.
   assign new_entry = (req_data.pad || (row_ff >= rows_ext)
                       || (req_data.cell_code == gncr_pkg::CODE_INVALID))
                      ? gncr_pkg::CODE_EMPTY : req_data.cell_code;

   // At column zero the window still holds the last cell of the row two rows
   // back as its right column; elsewhere the cell left of the incoming one is
   // decided with the incoming column on the right, before it is shifted in.
   assign path_end = (col_ff == '0) && (row_ff >= ROW_W'(2)) && (row_ff <= rows_p1);
   assign path_mid = (col_ff != '0) && (row_ff >= ROW_W'(1)) && (row_ff <= rows_ext);
   assign emit     = step && (path_end || path_mid);
   assign last     = path_end && (row_ff == rows_p1);
   assign row_done = (col_ext + LEN_W'(1)) >= len_ff;

   always_comb begin
      if (path_end) begin
         mask.no_top   = (row_ff == ROW_W'(2));
         mask.no_left  = (len_ff == LEN_W'(1));
         mask.no_right = 1'b1;
      end else begin
         mask.no_top   = (row_ff == ROW_W'(1));
         mask.no_left  = (col_ff == COL_W'(1));
         mask.no_right = 1'b0;
      end
   end

   // The store returns {upper, middle} for the current column.
   assign right_col.top = store_rd[3:2];
   assign right_col.mid = store_rd[1:0];
   assign right_col.bot = new_entry;
   assign store_wr      = {store_rd[1:0], new_entry};

   gncr_row_store #(
      .DEPTH  (MAX_ROW_LENGTH),
      .ADDR_W (COL_W),
      .DATA_W (4)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (col_ff),
      .wr_data (store_wr),
      .rd_addr (col_in),
      .rd_data (store_rd)
   );

   // Window chain: the new column enters at the right and moves left.
   assign feed[2] = right_col;
   assign feed[1] = win[2];
   assign feed[0] = win[1];

   for (genvar k = 0; k < 3; k++) begin : g_cell
      gncr_column_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (step),
         .column_feed (feed[k]),
         .column_out  (win[k])
      );
   end

   // The judge sees the window before the shift: its left and center columns
   // are win[1] and win[2], so both decision points see the same two columns.
   gncr_judge u_judge (
      .left_col   (win[1]),
      .center_col (win[2]),
      .right_col  (right_col),
      .mask       (mask),
      .threshold  (thr_ff),
      .new_code   (judge_code),
      .remove     (judge_remove)
   );

   assign count_upd = (emit && judge_remove && (count_ff != gncr_pkg::COUNT_MAX))
                      ? count_ff + COUNT_W'(1) : count_ff;

   // Clamp a row length write to the range the line store can hold.
   always_comb begin
      len_wr = {{(32 - gncr_pkg::LENGTH_W){1'b0}}, csr_wdata[gncr_pkg::LENGTH_W-1:0]};
      if (len_wr == 32'd0) begin
         len_wr = 32'd1;
      end else if (len_wr > 32'(MAX_ROW_LENGTH)) begin
         len_wr = 32'(MAX_ROW_LENGTH);
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      count_in = count_ff;
      len_in   = len_ff;
      rows_in  = rows_ff;
      thr_in   = thr_ff;
      if (step) begin
         count_in = count_upd;
         if (row_done) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
         if (emit && last) begin
            col_in   = '0;
            row_in   = '0;
            count_in = '0;
         end
      end
      if (csr_write_en) begin
         unique case (csr_index)
            gncr_pkg::CSR_ROW_LENGTH: begin
               len_in   = len_wr[LEN_W-1:0];
               col_in   = '0;
               row_in   = '0;
               count_in = '0;
            end
            gncr_pkg::CSR_ROW_COUNT: begin
               rows_in  = (csr_wdata == '0) ? ROWS_W'(1) : csr_wdata[ROWS_W-1:0];
               col_in   = '0;
               row_in   = '0;
               count_in = '0;
            end
            gncr_pkg::CSR_THRESHOLD: begin
               thr_in = csr_wdata[gncr_pkg::THR_W-1:0];
            end
            default: begin
               thr_in = thr_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.new_cell_code  = judge_code;
         rsp_data_in.removed_total  = count_upd;
         rsp_data_in.last_cell      = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         count_ff     <= '0;
         len_ff       <= LEN_W'(RESET_LEN);
         rows_ff      <= gncr_pkg::ROWS_RESET;
         thr_ff       <= gncr_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         rows_ff      <= rows_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // The column position never reaches the configured row length.
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ext < len_ff)
      else $error("column position outside the row");

   // The row position never runs past the flush row.
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= rows_p1)
      else $error("row position beyond the flush row");

   // The last cell of a frame restarts position and removal count.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      emit && last |=> (col_ff == '0) && (row_ff == '0) && (count_ff == '0))
      else $error("frame did not restart after its last cell");

   // A swallowed pad leaves position and count untouched.
   a_pad_idle: assert property (@(posedge clock) disable iff (reset)
      accept && ignore_pad && !csr_write_en
      |=> $stable(col_ff) && $stable(row_ff) && $stable(count_ff))
      else $error("idle pad item moved the position");

   // A result is produced only when the output register can take it.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result produced while output register is full");
`endif

endmodule

`default_nettype wire

// ----- dv/gncr_result_checker.sv -----
// Result checker for the grid neighbor count removal pass.
// Watches the item, result and register ports, predicts each result and compares.
// Depends on gncr_pkg for the item structs, cell codes and register indexes.
`timescale 1ns / 1ps

module gncr_result_checker #(
   parameter int MAX_ROW_LENGTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  gncr_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  gncr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [gncr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gncr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int CODE_W   = gncr_pkg::CODE_W;
   localparam int COUNT_W  = gncr_pkg::COUNT_W;
   localparam int LENGTH_W = gncr_pkg::LENGTH_W;
   localparam int ROWS_W   = gncr_pkg::ROWS_W;
   localparam int THR_W    = gncr_pkg::THR_W;

   // Predicted copy of the block's state and configuration.
   logic [CODE_W-1:0]   upper_row [MAX_ROW_LENGTH];
   logic [CODE_W-1:0]   middle_row [MAX_ROW_LENGTH];
   logic [CODE_W-1:0]   window_grid [3][3];
   int unsigned         col_pos;
   int unsigned         row_pos;
   logic [COUNT_W-1:0]  removed_run;
   logic [LENGTH_W-1:0] cfg_length;
   logic [ROWS_W-1:0]   cfg_rows;
   logic [THR_W-1:0]    cfg_threshold;

   gncr_pkg::rsp_type expected_cells [$];
   gncr_pkg::rsp_type oldest;
   gncr_pkg::rsp_type predicted;
   bit      produced;
   int      mismatch_total = 0;
   int      idx;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      removed_run = '0;
   endfunction

   // Decides one center from three window columns (left, center, right); a
   // negative column index or a set mask leaves that part out of the count.
   function automatic logic [CODE_W-1:0] erode_center(input int left_col, input int mid_col,
                                                       input int right_col, input bit no_top,
                                                       input bit no_left, input bit no_right);
      int          picks [3];
      int unsigned neighbors;
      logic [CODE_W-1:0] center;
      picks[0] = left_col;
      picks[1] = mid_col;
      picks[2] = right_col;
      neighbors = 0;
      for (int k = 0; k < 3; k++) begin
         if ((k == 0 && no_left) || (k == 2 && no_right) || picks[k] < 0) continue;
         for (int rr = 0; rr < 3; rr++) begin
            if (rr == 0 && no_top) continue;
            if (k == 1 && rr == 1) continue;
            if (window_grid[rr][picks[k]] == gncr_pkg::CODE_OCCUPIED) neighbors++;
         end
      end
      center = window_grid[1][mid_col];
      if (center == gncr_pkg::CODE_REMOVED) return gncr_pkg::CODE_REMOVED;
      if (center != gncr_pkg::CODE_OCCUPIED) return gncr_pkg::CODE_EMPTY;
      if (neighbors < cfg_threshold) begin
         if (removed_run < gncr_pkg::COUNT_MAX) removed_run++;
         return gncr_pkg::CODE_REMOVED;
      end
      return gncr_pkg::CODE_OCCUPIED;
   endfunction

   // Advances the predicted state by one accepted item.
   function automatic void advance_cell(input gncr_pkg::req_type item, output bit emitted,
                                        output gncr_pkg::rsp_type res);
      int unsigned       len_eff;
      int unsigned       rows_eff;
      int unsigned       c;
      int unsigned       r;
      logic [CODE_W-1:0] incoming;
      logic [CODE_W-1:0] code;
      bit                last;
      len_eff = (cfg_length == 0) ? 1 :
                (cfg_length > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : cfg_length;
      rows_eff = (cfg_rows == 0) ? 1 : cfg_rows;
      c = col_pos;
      r = row_pos;
      emitted = 0;
      last = 0;
      code = gncr_pkg::CODE_EMPTY;
      res = '0;
      if (c >= len_eff) c = 0;
      if (item.pad && c == 0 && r == 0) return;
      incoming = item.cell_code;
      if (item.pad || r >= rows_eff || incoming == gncr_pkg::CODE_INVALID) begin
         incoming = gncr_pkg::CODE_EMPTY;
      end

      // At the start of a row the last cell of the row two up is decided.
      if (c == 0 && r >= 2 && r - 2 < rows_eff) begin
         code = erode_center(1, 2, -1, r == 2, len_eff == 1, 1'b1);
         emitted = 1;
         last = (r - 2 == rows_eff - 1);
      end

      for (int k = 0; k < 3; k++) begin
         window_grid[k][0] = window_grid[k][1];
         window_grid[k][1] = window_grid[k][2];
      end
      window_grid[0][2] = upper_row[c];
      window_grid[1][2] = middle_row[c];
      window_grid[2][2] = incoming;
      upper_row[c] = middle_row[c];
      middle_row[c] = incoming;

      if (c >= 1 && r >= 1 && r - 1 < rows_eff) begin
         code = erode_center(0, 1, 2, r == 1, c == 1, 1'b0);
         emitted = 1;
      end

      c++;
      if (c >= len_eff) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r;

      if (!emitted) return;
      res.new_cell_code = code;
      res.removed_total = removed_run;
      res.last_cell = last;
      if (last) restart_frame();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (idx = 0; idx < MAX_ROW_LENGTH; idx++) begin
            upper_row[idx] = gncr_pkg::CODE_EMPTY;
            middle_row[idx] = gncr_pkg::CODE_EMPTY;
         end
         for (idx = 0; idx < 9; idx++) window_grid[idx / 3][idx % 3] = gncr_pkg::CODE_EMPTY;
         cfg_length = LENGTH_W'(256);
         cfg_rows = gncr_pkg::ROWS_RESET;
         cfg_threshold = gncr_pkg::THR_RESET;
         restart_frame();
         expected_cells.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: result with none expected: expected nothing, actual %p",
                        $time, rsp_data);
               mismatch_total++;
            end else begin
               oldest = expected_cells.pop_front();
               if (rsp_data.new_cell_code !== oldest.new_cell_code) begin
                  $display("%0t: new_cell_code expected %0d, actual %0d", $time,
                           oldest.new_cell_code, rsp_data.new_cell_code);
                  mismatch_total++;
               end
               if (rsp_data.removed_total !== oldest.removed_total) begin
                  $display("%0t: removed_total expected %0d, actual %0d", $time,
                           oldest.removed_total, rsp_data.removed_total);
                  mismatch_total++;
               end
               if (rsp_data.last_cell !== oldest.last_cell) begin
                  $display("%0t: last_cell expected %0d, actual %0d", $time,
                           oldest.last_cell, rsp_data.last_cell);
                  mismatch_total++;
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               gncr_pkg::CSR_ROW_LENGTH: begin
                  cfg_length = csr_wdata[LENGTH_W-1:0];
                  restart_frame();
               end
               gncr_pkg::CSR_ROW_COUNT: begin
                  cfg_rows = csr_wdata[ROWS_W-1:0];
                  restart_frame();
               end
               gncr_pkg::CSR_THRESHOLD: cfg_threshold = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_cell(req_data, produced, predicted);
            if (produced) expected_cells.insert(expected_cells.size(), predicted);
         end
      end
      fail_count <= mismatch_total;
      pending <= expected_cells.size();
   end

endmodule

// ----- dv/grid_neighbor_count_removal_pass_test.sv -----
// Testbench top for the grid neighbor count removal pass.
// Drives items and register writes, stalls the result side and gives the verdict;
// depends on gncr_pkg, the block and gncr_result_checker.
`timescale 1ns / 1ps

module grid_neighbor_count_removal_pass_test;

   localparam int MAX_ROW_LENGTH        = 256;
   localparam int CYCLE_LIMIT           = 100000;
   localparam int SETTLE_CYCLES         = 16;
   localparam int HOLD_CYCLES           = 300;
   localparam int RANDOM_ITEMS_PER_MODE = 80;
   localparam int CODE_W                = gncr_pkg::CODE_W;
   localparam int LENGTH_W              = gncr_pkg::LENGTH_W;
   localparam int ROWS_W                = gncr_pkg::ROWS_W;
   localparam int THR_W                 = gncr_pkg::THR_W;
   localparam int CSR_INDEX_W           = gncr_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W            = gncr_pkg::CSR_DATA_W;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   gncr_pkg::req_type      req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   gncr_pkg::rsp_type      rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int fail_count;
   int pending;

   // Pacing of both sides, in percent of cycles, changed from phase to phase.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // A long receiver hold-off is requested by bumping hold_seq; the receiver
   // process notices the change and counts the hold down on its own.
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int cycle_count = 0;
   int items_sent = 0;

   // Effective geometry as the block will use it, after clamping.
   int cur_len = MAX_ROW_LENGTH;
   int cur_rows = 256;

   always #5 clock = ~clock;

   grid_neighbor_count_removal_pass #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   gncr_result_checker #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
   ) result_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   // The receiver either honors a requested hold-off or stalls at random.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: a run that hangs or never drains ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic gncr_pkg::req_type make_item(input logic [CODE_W-1:0] code,
                                                   input logic pad);
      gncr_pkg::req_type item;
      item.cell_code = code;
      item.pad = pad;
      return item;
   endfunction

   // Draws a cell code with the given share of occupied cells; the rest is
   // mostly empty, with removed cells and the unused code three mixed in.
   function automatic logic [CODE_W-1:0] pick_code(input int occ_pct);
      int roll;
      if ($urandom_range(99) < occ_pct) return gncr_pkg::CODE_OCCUPIED;
      roll = $urandom_range(9);
      if (roll < 6) return gncr_pkg::CODE_EMPTY;
      if (roll < 9) return gncr_pkg::CODE_REMOVED;
      return gncr_pkg::CODE_INVALID;
   endfunction

   // Offers one item after a random idle gap and waits until it is accepted.
   // When there is no gap, valid simply stays high for the next item.
   task automatic send_item(input gncr_pkg::req_type item, input bit counts);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (counts) items_sent++;
   endtask

   task automatic send_cell(input logic [CODE_W-1:0] code);
      send_item(make_item(code, 1'b0), 1'b1);
   endtask

   // Pads carry random code bits, which the block must disregard.
   task automatic send_pads(input int count, input bit counts);
      repeat (count) send_item(make_item(CODE_W'($urandom_range(3)), 1'b1), counts);
   endtask

   // Sends one frame for the current geometry followed by its flush. A broken
   // frame scatters pad items among the cells and ends with a flush that is
   // too short, too long or partly made of ordinary cells.
   task automatic send_frame(input int occ_pct, input bit broken);
      int total;
      int flush;
      total = cur_len * cur_rows;
      flush = broken ? $urandom_range(0, cur_len + 3) : cur_len + 1;
      repeat (total) begin
         send_item(make_item(pick_code(occ_pct), broken && ($urandom_range(9) == 0)), 1'b1);
      end
      repeat (flush) begin
         send_item(make_item(CODE_W'($urandom_range(3)),
                             broken ? 1'($urandom_range(1)) : 1'b1), 1'b1);
      end
   endtask

   // Waits until every predicted result has come out, then lets the block
   // settle, so that it is idle before registers are written or the run ends.
   // The first edge lets the count of predicted results catch up with the
   // item that was accepted last.
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive cycles while the block is idle.
   task automatic set_geometry(input logic [LENGTH_W-1:0] row_len,
                               input logic [ROWS_W-1:0] rows,
                               input logic [THR_W-1:0] thr);
      settle_block();
      csr_write_en <= 1'b1;
      csr_index <= gncr_pkg::CSR_ROW_LENGTH;
      csr_wdata <= CSR_DATA_W'(row_len);
      @(posedge clock);
      csr_index <= gncr_pkg::CSR_ROW_COUNT;
      csr_wdata <= CSR_DATA_W'(rows);
      @(posedge clock);
      csr_index <= gncr_pkg::CSR_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_len = (row_len == 0) ? 1 : (row_len > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : row_len;
      cur_rows = (rows == 0) ? 1 : rows;
   endtask

   // One random phase at the given pacing. Most geometries are small; now
   // and then a zero register value or an over-long row shows up. Well-formed
   // frames run back to back so that the end-of-frame restart is exercised,
   // with stray pads at the frame start and the odd broken frame in between.
   task automatic run_random_phase(input int send_pct, input int stall_pct);
      int goal;
      int sel;
      logic [LENGTH_W-1:0] row_len;
      logic [ROWS_W-1:0]   rows;
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      goal = items_sent + RANDOM_ITEMS_PER_MODE;
      while (items_sent < goal) begin
         sel = $urandom_range(49);
         if (sel == 0) begin
            row_len = '0;
         end else if (sel == 1) begin
            row_len = LENGTH_W'($urandom_range(MAX_ROW_LENGTH, 511));
         end else begin
            row_len = LENGTH_W'($urandom_range(1, 10));
         end
         rows = ($urandom_range(9) == 0) ? '0 : ROWS_W'($urandom_range(1, 6));
         if (sel == 1) rows = ROWS_W'(1);
         set_geometry(row_len, rows, THR_W'($urandom_range(15)));
         repeat ($urandom_range(1, 3)) begin
            send_frame($urandom_range(30, 95), 1'b0);
            if ($urandom_range(3) == 0) send_pads($urandom_range(1, 3), 1'b0);
         end
         if ($urandom_range(4) == 0) send_frame($urandom_range(10, 90), 1'b1);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = gncr_pkg::CSR_ROW_LENGTH;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A pad item at the very start of a frame is swallowed with no result.
      send_item(make_item(gncr_pkg::CODE_OCCUPIED, 1'b1), 1'b0);

      // A small grid with every cell code, including code three, at the
      // default threshold; the corners and edges see neighbors outside the grid.
      set_geometry(LENGTH_W'(3), ROWS_W'(3), THR_W'(4));
      send_cell(gncr_pkg::CODE_OCCUPIED);
      send_cell(gncr_pkg::CODE_OCCUPIED);
      send_cell(gncr_pkg::CODE_EMPTY);
      send_cell(gncr_pkg::CODE_OCCUPIED);
      send_cell(gncr_pkg::CODE_OCCUPIED);
      send_cell(gncr_pkg::CODE_REMOVED);
      send_cell(gncr_pkg::CODE_INVALID);
      send_cell(gncr_pkg::CODE_OCCUPIED);
      send_cell(gncr_pkg::CODE_OCCUPIED);
      send_pads(4, 1'b1);

      // A single-cell grid with a threshold above eight: the cell must go.
      set_geometry(LENGTH_W'(1), ROWS_W'(1), THR_W'(15));
      send_cell(gncr_pkg::CODE_OCCUPIED);
      send_pads(2, 1'b1);

      // A zero threshold removes nothing from a full two by two grid.
      set_geometry(LENGTH_W'(2), ROWS_W'(2), THR_W'(0));
      repeat (4) send_cell(gncr_pkg::CODE_OCCUPIED);
      send_pads(3, 1'b1);

      // The largest row count, left unfinished; the next write restarts it.
      set_geometry(LENGTH_W'(1), ROWS_W'(16'hFFFF), THR_W'(2));
      repeat (50) send_cell(pick_code(60));

      // Full-length rows while the receiver holds off for a long stretch, so
      // that the block fills up and has to stall its input.
      set_geometry(LENGTH_W'(MAX_ROW_LENGTH), ROWS_W'(2), THR_W'(3));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_seq <= hold_seq + 1;
      send_frame(60, 1'b0);

      run_random_phase(0, 0);
      run_random_phase(72, 0);
      run_random_phase(0, 72);

      // The widest row length value, which the block clamps to its maximum.
      send_idle_pct = 31;
      recv_stall_pct = 31;
      set_geometry(LENGTH_W'(511), ROWS_W'(1), THR_W'(5));
      send_frame(70, 1'b0);
      run_random_phase(31, 31);

      settle_block();
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
